### src/grid_slot_table_assert.svh
// grid_slot_table_assert.svh
// assertion macros shared by the grid slot table checker
// the including scope must provide clk and rst_n
`ifndef GRID_SLOT_TABLE_ASSERT_SVH
`define GRID_SLOT_TABLE_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define GST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid slot table check failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define GST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid slot table check failed");

`endif

### src/gst_pkg.sv
// gst_pkg.sv
// shared types and constants of the grid slot table
// no dependencies
package gst_pkg;

    // fixed field widths of the ports
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int PLACE_W    = 3;
    localparam int EMPTY_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [EMPTY_W-1:0]    EMPTY_SAT        = 7'd127;
    localparam logic [CFG_DATA_W-1:0] ROWS_IN_USE_INIT = 4'd8;
    localparam logic [CFG_DATA_W-1:0] COLS_IN_USE_INIT = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT_FIRST = 2'd0,
        CMD_INSERT_AT    = 2'd1,
        CMD_REMOVE_AT    = 2'd2,
        CMD_QUERY_AT     = 2'd3
    } gst_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_OCCUPIED  = 3'd3,
        ST_EMPTY     = 3'd4
    } gst_status_t;

    // occupancy update issued by the sequencer
    typedef struct packed {
        logic set;
        logic clr;
    } gst_upd_t;

    // occupancy map status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic found;
    } gst_occ_stat_t;

endpackage

### src/grid_slot_table.sv
// Grid slot table: a MAX_ROWS x MAX_COLS grid of slots, each holding one
// item handle and an occupancy bit, of which the first rows_in_use rows and
// cols_in_use columns are in use (values above the maximum count as the
// maximum, zero leaves no slot in use). Commands: insert into the first free
// slot in row-major order, insert at, remove at and query a slot; every
// result carries the empty slot count and a full flag after the command.
// Sequence: the accept cycle resolves the slot and issues the registered
// memory read; the S_EXEC state does the read-modify-write and loads
// the output register. A new transaction is taken while the previous
// result waits in the output register; it holds in S_EXEC until that
// register frees up. After reset and after every configuration write the
// empty count is rebuilt by a sweep over all MAX_ROWS rows, one row a
// cycle, during which in_ready is low. The user must write configuration
// only while the block is idle; the block itself does not enforce it.
// Depends on gst_pkg, gst_occ and gst_item_mem.
module grid_slot_table #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 8,
    parameter int ITEM_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [gst_pkg::CMD_W-1:0]        cmd,
    input  logic [gst_pkg::IDX_W-1:0]        row,
    input  logic [gst_pkg::IDX_W-1:0]        col,
    input  logic [ITEM_BITS-1:0]             item,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [gst_pkg::STATUS_W-1:0]     status,
    output logic [ITEM_BITS-1:0]             item_out,
    output logic                             slot_used,
    output logic [gst_pkg::PLACE_W-1:0]      placed_row,
    output logic [gst_pkg::PLACE_W-1:0]      placed_col,
    output logic [gst_pkg::EMPTY_W-1:0]      empty_count,
    output logic                             table_full,
    // configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gst_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gst_pkg::*;

    localparam int SLOTS  = MAX_ROWS * MAX_COLS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int REW    = $clog2(MAX_ROWS + 1);
    localparam int CEW    = $clog2(MAX_COLS + 1);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SAT_W  = (CNT_W > EMPTY_W) ? CNT_W : EMPTY_W;
    localparam int PRW    = (RW > PLACE_W) ? RW : PLACE_W;
    localparam int PCW    = (CW > PLACE_W) ? CW : PLACE_W;
    localparam int CMP_W  = ((REW > IDX_W) ? REW : IDX_W) + 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t               state_reg;

    // configuration registers
    logic [CFG_DATA_W-1:0] rows_in_use_reg;
    logic [CFG_DATA_W-1:0] cols_in_use_reg;
    logic [REW-1:0]        rows_eff;
    logic [CEW-1:0]        cols_eff;
    logic                  cfg_fire;

    // transaction in flight
    gst_cmd_t              cmd_reg;
    logic [ITEM_BITS-1:0]  item_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [RW-1:0]         prow_reg;
    logic [CW-1:0]         pcol_reg;
    logic                  bad_reg;
    logic                  occ_bit_reg;

    // output register
    logic                  out_valid_reg;
    gst_status_t           status_reg;
    logic [ITEM_BITS-1:0]  item_out_reg;
    logic                  slot_used_reg;
    logic [PLACE_W-1:0]    placed_row_reg;
    logic [PLACE_W-1:0]    placed_col_reg;
    logic [EMPTY_W-1:0]    empty_count_reg;
    logic                  table_full_reg;

    // accept side
    logic                  in_fire;
    gst_cmd_t              acc_cmd;
    logic                  acc_bad;
    logic [SLOT_W-1:0]     acc_slot;
    logic [RW-1:0]         row_idx;
    logic [CW-1:0]         col_idx;

    // occupancy map interface
    logic                  occ_rd_bit;
    logic [RW-1:0]         ff_row;
    logic [CW-1:0]         ff_col;
    logic [SLOT_W-1:0]     ff_idx;
    gst_occ_stat_t         occ_stat;
    logic [CNT_W-1:0]      count_post;

    // execute side
    logic                  exec_fire;
    gst_upd_t              upd;
    gst_upd_t              upd_q;
    logic [ITEM_BITS-1:0]  mem_rdata;
    gst_status_t           res_status;
    logic [ITEM_BITS-1:0]  res_item;
    logic                  res_used;
    logic [RW-1:0]         res_prow;
    logic [CW-1:0]         res_pcol;
    logic [SAT_W-1:0]      count_ext;
    logic [EMPTY_W-1:0]    count_sat;
    logic [PRW-1:0]        prow_ext;
    logic [PCW-1:0]        pcol_ext;

    // effective grid size, capped at the physical grid
    assign rows_eff = (int'(rows_in_use_reg) > MAX_ROWS) ? REW'(MAX_ROWS) : REW'(rows_in_use_reg);
    assign cols_eff = (int'(cols_in_use_reg) > MAX_COLS) ? CEW'(MAX_COLS) : CEW'(cols_in_use_reg);

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // a new transaction enters only in idle and not during a count sweep
    assign in_ready  = (state_reg == S_IDLE) & ~occ_stat.busy;
    assign in_fire   = in_valid & in_ready;

    // the execute cycle proceeds once the output register can take the result
    assign exec_fire = (state_reg == S_EXEC) & (~out_valid_reg | out_ready);

    // slot resolution at accept: first free slot or addressed slot
    assign acc_cmd = gst_cmd_t'(cmd);
    assign row_idx = row[RW-1:0];
    assign col_idx = col[CW-1:0];

    always_comb
    begin
        if (acc_cmd == CMD_INSERT_FIRST)
        begin
            acc_bad  = ~occ_stat.found;
            acc_slot = ff_idx;
        end
        else
        begin
            acc_bad  = (CMP_W'(row) >= CMP_W'(rows_eff)) | (CMP_W'(col) >= CMP_W'(cols_eff));
            acc_slot = SLOT_W'(int'(row_idx) * MAX_COLS + int'(col_idx));
        end
    end

    // execute: decide the result and the occupancy update
    always_comb
    begin
        upd        = '0;
        res_status = ST_OK;
        res_item   = '0;
        res_used   = 1'b0;
        res_prow   = '0;
        res_pcol   = '0;
        case (cmd_reg)
            CMD_INSERT_FIRST:
            begin
                if (bad_reg)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    upd.set  = 1'b1;
                    res_item = item_reg;
                    res_used = 1'b1;
                    res_prow = prow_reg;
                    res_pcol = pcol_reg;
                end
            end
            CMD_INSERT_AT:
            begin
                if (bad_reg)
                begin
                    res_status = ST_BAD_INDEX;
                end
                else if (occ_bit_reg)
                begin
                    // slot keeps its item, which is shown back
                    res_status = ST_OCCUPIED;
                    res_item   = mem_rdata;
                    res_used   = 1'b1;
                end
                else
                begin
                    upd.set  = 1'b1;
                    res_item = item_reg;
                    res_used = 1'b1;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (bad_reg)
                begin
                    res_status = ST_BAD_INDEX;
                end
                else if (occ_bit_reg)
                begin
                    upd.clr = 1'b1;
                end
                else
                begin
                    res_status = ST_EMPTY;
                end
            end
            CMD_QUERY_AT:
            begin
                if (bad_reg)
                begin
                    res_status = ST_BAD_INDEX;
                end
                else if (occ_bit_reg)
                begin
                    res_item = mem_rdata;
                    res_used = 1'b1;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    assign upd_q = exec_fire ? upd : '0;

    // empty count after the command, saturated to the port width
    assign count_ext = SAT_W'(count_post);
    assign count_sat = (count_ext > SAT_W'(EMPTY_SAT)) ? EMPTY_SAT : count_ext[EMPTY_W-1:0];
    assign prow_ext  = PRW'(res_prow);
    assign pcol_ext  = PCW'(res_pcol);

    gst_occ #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .SLOTS    (SLOTS),
        .SLOT_W   (SLOT_W),
        .RW       (RW),
        .CW       (CW),
        .REW      (REW),
        .CEW      (CEW),
        .CNT_W    (CNT_W)
    ) u_occ (
        .clk        (clk),
        .rst_n      (rst_n),
        .rows_eff   (rows_eff),
        .cols_eff   (cols_eff),
        .recount    (cfg_fire),
        .upd        (upd_q),
        .upd_idx    (slot_reg),
        .rd_idx     (acc_slot),
        .rd_bit     (occ_rd_bit),
        .ff_row     (ff_row),
        .ff_col     (ff_col),
        .ff_idx     (ff_idx),
        .stat       (occ_stat),
        .count_post (count_post)
    );

    gst_item_mem #(
        .DEPTH (SLOTS),
        .AW    (SLOT_W),
        .DW    (ITEM_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (upd_q.set),
        .waddr (slot_reg),
        .wdata (item_reg),
        .re    (in_fire),
        .raddr (acc_slot),
        .rdata (mem_rdata)
    );

    // transaction capture at accept
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg     <= acc_cmd;
            item_reg    <= item;
            slot_reg    <= acc_slot;
            prow_reg    <= ff_row;
            pcol_reg    <= ff_col;
            bad_reg     <= acc_bad;
            occ_bit_reg <= occ_rd_bit;
        end
    end

    // sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rows_in_use_reg <= ROWS_IN_USE_INIT;
            cols_in_use_reg <= COLS_IN_USE_INIT;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            item_out_reg    <= '0;
            slot_used_reg   <= 1'b0;
            placed_row_reg  <= '0;
            placed_col_reg  <= '0;
            empty_count_reg <= '0;
            table_full_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                if (cfg_index == REG_ROWS_IN_USE)
                begin
                    rows_in_use_reg <= cfg_data;
                end
                else if (cfg_index == REG_COLS_IN_USE)
                begin
                    cols_in_use_reg <= cfg_data;
                end
            end
            // result taken with no new one arriving in the same cycle
            if (out_valid_reg && out_ready && !exec_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (exec_fire)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= res_status;
                        item_out_reg    <= res_item;
                        slot_used_reg   <= res_used;
                        placed_row_reg  <= prow_ext[PLACE_W-1:0];
                        placed_col_reg  <= pcol_ext[PLACE_W-1:0];
                        empty_count_reg <= count_sat;
                        table_full_reg  <= (count_post == '0);
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign item_out    = item_out_reg;
    assign slot_used   = slot_used_reg;
    assign placed_row  = placed_row_reg;
    assign placed_col  = placed_col_reg;
    assign empty_count = empty_count_reg;
    assign table_full  = table_full_reg;

endmodule

### src/gst_item_mem.sv
// gst_item_mem.sv
// item handle store: one write port, one registered read port
// no package dependencies
module gst_item_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/gst_occ.sv
// gst_occ.sv
// occupancy bitmap, first-free search and empty slot counter
// depends on gst_pkg
module gst_occ #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    parameter int SLOTS    = 64,
    parameter int SLOT_W   = 6,
    parameter int RW       = 3,
    parameter int CW       = 3,
    parameter int REW      = 4,
    parameter int CEW      = 4,
    parameter int CNT_W    = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [REW-1:0]         rows_eff,
    input  logic [CEW-1:0]         cols_eff,
    input  logic                   recount,
    input  gst_pkg::gst_upd_t      upd,
    input  logic [SLOT_W-1:0]      upd_idx,
    input  logic [SLOT_W-1:0]      rd_idx,
    output logic                   rd_bit,
    output logic [RW-1:0]          ff_row,
    output logic [CW-1:0]          ff_col,
    output logic [SLOT_W-1:0]      ff_idx,
    output gst_pkg::gst_occ_stat_t stat,
    output logic [CNT_W-1:0]       count_post
);
    import gst_pkg::*;

    localparam int POP_W = $clog2(MAX_COLS + 1);

    logic [SLOTS-1:0]    occ_reg;
    logic                busy_reg;
    logic [RW-1:0]       rc_row_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [MAX_ROWS-1:0] row_en;
    logic [MAX_COLS-1:0] col_en;
    logic [MAX_ROWS-1:0] row_free;
    logic [MAX_COLS-1:0] sel_free;
    logic [MAX_COLS-1:0] rc_free;
    logic [POP_W-1:0]    rc_pop;

    // slots in use
    always_comb
    begin
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            row_en[r] = (r < int'(rows_eff));
        end
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_en[c] = (c < int'(cols_eff));
        end
    end

    // first free slot: lowest row with a free slot, then lowest column there
    always_comb
    begin
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            row_free[r] = row_en[r] & (|(~occ_reg[r*MAX_COLS +: MAX_COLS] & col_en));
        end
        ff_row = '0;
        for (int r = MAX_ROWS - 1; r >= 0; r--)
        begin
            if (row_free[r])
            begin
                ff_row = RW'(r);
            end
        end
        sel_free = ~occ_reg[int'(ff_row)*MAX_COLS +: MAX_COLS] & col_en;
        ff_col = '0;
        for (int c = MAX_COLS - 1; c >= 0; c--)
        begin
            if (sel_free[c])
            begin
                ff_col = CW'(c);
            end
        end
        ff_idx = SLOT_W'(int'(ff_row) * MAX_COLS + int'(ff_col));
    end

    assign rd_bit     = occ_reg[rd_idx];
    assign stat.busy  = busy_reg;
    assign stat.found = |row_free;

    // free slots of the row under recount
    always_comb
    begin
        rc_free = ~occ_reg[int'(rc_row_reg)*MAX_COLS +: MAX_COLS] & col_en;
        rc_pop  = '0;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            rc_pop = rc_pop + POP_W'(rc_free[c]);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (upd.set)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (upd.clr)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign count_post = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            busy_reg   <= 1'b1;
            rc_row_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (upd.set)
            begin
                occ_reg[upd_idx] <= 1'b1;
            end
            if (upd.clr)
            begin
                occ_reg[upd_idx] <= 1'b0;
            end
            if (recount)
            begin
                busy_reg   <= 1'b1;
                rc_row_reg <= '0;
                count_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (row_en[rc_row_reg])
                begin
                    count_reg <= count_reg + CNT_W'(rc_pop);
                end
                if (rc_row_reg == RW'(MAX_ROWS - 1))
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    rc_row_reg <= rc_row_reg + RW'(1);
                end
            end
            else
            begin
                count_reg <= count_next;
            end
        end
    end

endmodule

### src/gst_checker.sv
// gst_checker.sv
// port-level checks of the grid slot table, bound to the top level
// depends on gst_pkg and grid_slot_table_assert.svh
`include "grid_slot_table_assert.svh"

module gst_checker #(
    parameter int ITEM_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [gst_pkg::STATUS_W-1:0]  status,
    input logic [ITEM_BITS-1:0]          item_out,
    input logic                          slot_used,
    input logic [gst_pkg::PLACE_W-1:0]   placed_row,
    input logic [gst_pkg::PLACE_W-1:0]   placed_col,
    input logic [gst_pkg::EMPTY_W-1:0]   empty_count,
    input logic                          table_full
);
    import gst_pkg::*;

    // a stalled result transaction holds
    `GST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(item_out) && $stable(empty_count))

    // full flag agrees with the empty count
    `GST_ASSERT_IMP(a_full_flag, out_valid, table_full == (empty_count == '0))

    // full, bad-index and empty-slot results show no item
    `GST_ASSERT_IMP(a_no_item, out_valid && (status == ST_FULL || status == ST_BAD_INDEX || status == ST_EMPTY), !slot_used && item_out == '0)

    // placement is only reported on success
    `GST_ASSERT_IMP(a_place_ok, out_valid && status != ST_OK, placed_row == '0 && placed_col == '0)

endmodule

bind grid_slot_table gst_checker #(.ITEM_BITS(ITEM_BITS)) u_gst_checker (.*);
